// ----- hdl/dht_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dht_pkg
// Shared types, register indexes, status codes and reset values for the
// single-wire humidity/temperature sensor reader.
// ----------------------------------------------------------------------------
package dht_pkg;

   localparam int CFG_WIDTH             = 16;
   localparam int CSR_INDEX_WIDTH       = 2;
   localparam int DATA_WIDTH            = 16;
   localparam int FRAME_BITS            = 40;
   localparam int BIT_INDEX_WIDTH       = 6;
   localparam int DEFAULT_COUNTER_WIDTH = 16;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_LOW_TICKS = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RELEASE_TICKS   = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TIMEOUT_LIMIT   = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ONE_THRESHOLD   = 2'd3;

   localparam logic [CFG_WIDTH-1:0] START_LOW_TICKS_RESET = 16'd1000;
   localparam logic [CFG_WIDTH-1:0] RELEASE_TICKS_RESET   = 16'd30;
   localparam logic [CFG_WIDTH-1:0] TIMEOUT_LIMIT_RESET   = 16'd100;
   localparam logic [CFG_WIDTH-1:0] ONE_THRESHOLD_RESET   = 16'd40;

   // reading status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_TIMEOUT  = 2'd1;
   localparam logic [1:0] STATUS_CHECKSUM = 2'd2;

   localparam logic [7:0] SIGN_MASK      = 8'h80;
   localparam logic [7:0] MAGNITUDE_MASK = 8'h7F;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] start_low_ticks;
      logic [CFG_WIDTH-1:0] release_ticks;
      logic [CFG_WIDTH-1:0] timeout_limit;
      logic [CFG_WIDTH-1:0] one_threshold;
   } cfg_type;

   typedef struct packed {
      logic line_level;
      logic start_request;
   } tick_type;

   typedef struct packed {
      logic                         drive_low;
      logic                         busy_res;
      logic                         done_res;
      logic [1:0]                   status;
      logic [DATA_WIDTH-1:0]        humidity_tenths;
      logic signed [DATA_WIDTH-1:0] temperature_tenths;
   } rsp_type;

endpackage

// ----- hdl/dht22_single_wire_reader.sv -----
`timescale 1ns / 1ps
// a request is held in the tick register, then its response is registered;
// throughput: one tick per cycle unless responses stall; the state machine
// steps on advance; the tick register refills as its held tick advances
// reset: synchronous, clears the state machine, results and channel valids,
// and loads the register defaults
// ----------------------------------------------------------------------------
// dht22_single_wire_reader
// Single-wire humidity/temperature sensor reader driven by microsecond ticks.
// ----------------------------------------------------------------------------
module dht22_single_wire_reader #(
   parameter int COUNTER_WIDTH = dht_pkg::DEFAULT_COUNTER_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_line_level,
   input  logic                                 req_start_request,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_drive_low,
   output logic                                 rsp_busy_res,
   output logic                                 rsp_done_res,
   output logic [1:0]                           rsp_status,
   output logic [dht_pkg::DATA_WIDTH-1:0]        rsp_humidity_tenths,
   output logic signed [dht_pkg::DATA_WIDTH-1:0] rsp_temperature_tenths,
   input  logic                                 csr_write_enable,
   input  logic [dht_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [dht_pkg::CFG_WIDTH-1:0]        csr_write_data
);
   import dht_pkg::*;

   cfg_type  cfg;
   tick_type tick_ff;
   logic     tick_valid_ff;
   rsp_type  rsp_next;
   rsp_type  rsp_ff;
   logic     rsp_valid_ff;
   logic     advance;

   // the held tick moves on when the response register is free or being read
   assign advance   = tick_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !tick_valid_ff || advance;

   dht_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   dht_sequencer #(
      .COUNTER_WIDTH (COUNTER_WIDTH)
   ) u_sequencer (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .tick     (tick_ff),
      .cfg      (cfg),
      .rsp_next (rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_valid_ff <= 1'b0;
      end else if (req_ready) begin
         tick_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         tick_ff.line_level    <= req_line_level;
         tick_ff.start_request <= req_start_request;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_drive_low          = rsp_ff.drive_low;
   assign rsp_busy_res           = rsp_ff.busy_res;
   assign rsp_done_res           = rsp_ff.done_res;
   assign rsp_status             = rsp_ff.status;
   assign rsp_humidity_tenths    = rsp_ff.humidity_tenths;
   assign rsp_temperature_tenths = rsp_ff.temperature_tenths;

endmodule

// ----- hdl/dht_csr.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dht_csr
// Configuration registers: timing of the start pulse, release window,
// level wait timeout and bit threshold.
// ----------------------------------------------------------------------------
module dht_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [dht_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [dht_pkg::CFG_WIDTH-1:0]        csr_write_data,
   output dht_pkg::cfg_type                     cfg
);
   import dht_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_low_ticks <= START_LOW_TICKS_RESET;
         cfg_ff.release_ticks   <= RELEASE_TICKS_RESET;
         cfg_ff.timeout_limit   <= TIMEOUT_LIMIT_RESET;
         cfg_ff.one_threshold   <= ONE_THRESHOLD_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_START_LOW_TICKS: cfg_ff.start_low_ticks <= csr_write_data;
            CSR_RELEASE_TICKS:   cfg_ff.release_ticks   <= csr_write_data;
            CSR_TIMEOUT_LIMIT:   cfg_ff.timeout_limit   <= csr_write_data;
            CSR_ONE_THRESHOLD:   cfg_ff.one_threshold   <= csr_write_data;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- hdl/dht_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dht_decode
// Frame decode: checksum check over the four data bytes, humidity word and
// sign-magnitude to two's complement temperature.
// ----------------------------------------------------------------------------
module dht_decode (
   input  logic [dht_pkg::FRAME_BITS-1:0]        frame,
   output logic                                  checksum_ok,
   output logic [dht_pkg::DATA_WIDTH-1:0]        humidity_tenths,
   output logic signed [dht_pkg::DATA_WIDTH-1:0] temperature_tenths
);
   import dht_pkg::*;

   logic [7:0]            byte0, byte1, byte2, byte3, byte4;
   logic [9:0]            byte_sum;
   logic [DATA_WIDTH-1:0] magnitude;

   assign byte0 = frame[39:32];
   assign byte1 = frame[31:24];
   assign byte2 = frame[23:16];
   assign byte3 = frame[15:8];
   assign byte4 = frame[7:0];

   assign byte_sum = {2'b00, byte0} + {2'b00, byte1} + {2'b00, byte2} + {2'b00, byte3};
   assign checksum_ok = (byte_sum[7:0] == byte4);

   assign humidity_tenths = {byte0, byte1};
   assign magnitude       = {byte2 & MAGNITUDE_MASK, byte3};

   // negative zero comes out as zero
   assign temperature_tenths = ((byte2 & SIGN_MASK) != 8'h00) ?
                               $signed(16'h0000 - magnitude) : $signed(magnitude);

endmodule

// ----- hdl/dht_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dht_sequencer
// Tick state machine: start pulse, release window, response levels and the
// forty timed data pulses, plus the latched reading results.
// ----------------------------------------------------------------------------
module dht_sequencer #(
   parameter int COUNTER_WIDTH = dht_pkg::DEFAULT_COUNTER_WIDTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  dht_pkg::tick_type tick,
   input  dht_pkg::cfg_type  cfg,
   output dht_pkg::rsp_type  rsp_next
);
   import dht_pkg::*;

   localparam int CMP_WIDTH = (COUNTER_WIDTH > CFG_WIDTH) ? COUNTER_WIDTH : CFG_WIDTH;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_START_LOW,
      PH_RELEASE,
      PH_RESP_LOW,
      PH_RESP_HIGH,
      PH_RESP_LOW2,
      PH_BIT_HIGH,
      PH_BIT_MEASURE
   } phase_type;

   phase_type                    phase_ff, phase_in;
   logic [COUNTER_WIDTH-1:0]     tick_count_ff, tick_count_in;
   logic [BIT_INDEX_WIDTH-1:0]   bit_index_ff, bit_index_in;
   logic [FRAME_BITS-1:0]        frame_ff, frame_in;
   logic [DATA_WIDTH-1:0]        humidity_ff, humidity_in;
   logic signed [DATA_WIDTH-1:0] temperature_ff, temperature_in;
   logic [1:0]                   status_ff, status_in;

   logic                         checksum_ok;
   logic [DATA_WIDTH-1:0]        frame_humidity;
   logic signed [DATA_WIDTH-1:0] frame_temperature;
   logic                         want_level;
   logic                         pulse_is_one;

   dht_decode u_decode (
      .frame              (frame_in),
      .checksum_ok        (checksum_ok),
      .humidity_tenths    (frame_humidity),
      .temperature_tenths (frame_temperature)
   );

   always_comb begin
      phase_in       = phase_ff;
      tick_count_in  = tick_count_ff;
      bit_index_in   = bit_index_ff;
      frame_in       = frame_ff;
      humidity_in    = humidity_ff;
      temperature_in = temperature_ff;
      status_in      = status_ff;
      want_level     = 1'b0;
      pulse_is_one   = 1'b0;

      // timed phases
      unique case (phase_ff)
         PH_IDLE: begin
            if (tick.start_request) begin
               phase_in      = PH_START_LOW;
               tick_count_in = COUNTER_WIDTH'(1);
               bit_index_in  = '0;
               frame_in      = '0;
            end
         end
         PH_START_LOW: begin
            if (CMP_WIDTH'(tick_count_ff) >= CMP_WIDTH'(cfg.start_low_ticks) ||
                (&tick_count_ff)) begin
               phase_in      = PH_RELEASE;
               tick_count_in = '0;
            end else begin
               tick_count_in = tick_count_ff + 1'b1;
            end
         end
         PH_RELEASE: begin
            if (CMP_WIDTH'(tick_count_ff) >= CMP_WIDTH'(cfg.release_ticks) ||
                (&tick_count_ff)) begin
               phase_in      = PH_RESP_LOW;
               tick_count_in = '0;
            end else begin
               tick_count_in = tick_count_ff + 1'b1;
            end
         end
         PH_RESP_LOW, PH_RESP_HIGH, PH_RESP_LOW2, PH_BIT_HIGH, PH_BIT_MEASURE: begin
         end
      endcase

      // level waits, also on the tick the release window closes
      if (phase_in == PH_RESP_LOW || phase_in == PH_RESP_HIGH ||
          phase_in == PH_RESP_LOW2 || phase_in == PH_BIT_HIGH ||
          phase_in == PH_BIT_MEASURE) begin
         want_level = (phase_in == PH_RESP_HIGH || phase_in == PH_BIT_HIGH);
         if (tick.line_level == want_level) begin
            pulse_is_one  = CMP_WIDTH'(tick_count_in) > CMP_WIDTH'(cfg.one_threshold);
            tick_count_in = '0;
            if (phase_in == PH_BIT_MEASURE) begin
               frame_in     = {frame_ff[FRAME_BITS-2:0], pulse_is_one};
               bit_index_in = bit_index_ff + 1'b1;
               if (bit_index_in >= BIT_INDEX_WIDTH'(FRAME_BITS)) begin
                  phase_in = PH_IDLE;
                  if (checksum_ok) begin
                     humidity_in    = frame_humidity;
                     temperature_in = frame_temperature;
                     status_in      = STATUS_OK;
                  end else begin
                     status_in = STATUS_CHECKSUM;
                  end
               end else begin
                  phase_in = PH_BIT_HIGH;
               end
            end else begin
               phase_in = phase_type'(phase_in + 3'd1);
            end
         end else if (CMP_WIDTH'(tick_count_in) >= CMP_WIDTH'(cfg.timeout_limit) ||
                      (&tick_count_in)) begin
            phase_in      = PH_IDLE;
            tick_count_in = '0;
            status_in     = STATUS_TIMEOUT;
         end else begin
            tick_count_in = tick_count_in + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         tick_count_ff  <= '0;
         bit_index_ff   <= '0;
         frame_ff       <= '0;
         humidity_ff    <= '0;
         temperature_ff <= '0;
         status_ff      <= STATUS_OK;
      end else if (advance) begin
         phase_ff       <= phase_in;
         tick_count_ff  <= tick_count_in;
         bit_index_ff   <= bit_index_in;
         frame_ff       <= frame_in;
         humidity_ff    <= humidity_in;
         temperature_ff <= temperature_in;
         status_ff      <= status_in;
      end
   end

   assign rsp_next.drive_low          = (phase_in == PH_START_LOW);
   assign rsp_next.busy_res           = (phase_in != PH_IDLE);
   assign rsp_next.done_res           = (phase_ff != PH_IDLE) && (phase_in == PH_IDLE);
   assign rsp_next.status             = status_in;
   assign rsp_next.humidity_tenths    = humidity_in;
   assign rsp_next.temperature_tenths = temperature_in;

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Tick-level testbench for the single-wire sensor reader. Ticks carrying the
// line level and start request go in over the request channel, with random
// gaps and response stalls. A cycle-accurate sensor reading model inside the
// testbench predicts every response tick and checks it field by field.
// Stimulus covers directed corner timing, then full frames under two register
// settings (random content in the second), cut-off frames and line noise.
// ----------------------------------------------------------------------------
module tb;
   import dht_pkg::*;

   localparam int CYCLE_LIMIT = 2_000_000;
   localparam logic [15:0] COUNT_FULL = 16'hFFFF;
   // hand-built corner sequence, first tick in the top bit
   localparam logic [20:0] DIRECTED_LINE  = 21'b010110000100110101011;
   localparam logic [20:0] DIRECTED_START = 21'b001111000100001000000;

   typedef enum logic [3:0] {
      SENSE_IDLE, SENSE_DRIVE, SENSE_RELEASE, SENSE_RESP_LOW, SENSE_RESP_HIGH,
      SENSE_RESP_LOW2, SENSE_BIT_HIGH, SENSE_BIT_MEASURE
   } sense_phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_line_level = 1'b0;
   logic req_start_request = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_drive_low;
   logic rsp_busy_res;
   logic rsp_done_res;
   logic [1:0] rsp_status;
   logic [DATA_WIDTH-1:0] rsp_humidity_tenths;
   logic signed [DATA_WIDTH-1:0] rsp_temperature_tenths;
   logic csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CFG_WIDTH-1:0] csr_write_data = '0;

   // sensor reading model state
   cfg_type cfg_copy;
   sense_phase_type sense_phase;
   logic [15:0] sense_count;
   logic [5:0] bits_seen;
   logic [39:0] frame_bits;
   logic [15:0] held_humidity;
   logic signed [15:0] held_temperature;
   logic [1:0] held_status;

   tick_type tick_backlog[$];
   rsp_type expected_readouts[$];
   tick_type next_tick;
   rsp_type want;
   int cycle_count = 0;
   int mismatch_count = 0;

   dht22_single_wire_reader dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_line_level(req_line_level),
      .req_start_request(req_start_request),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_drive_low(rsp_drive_low),
      .rsp_busy_res(rsp_busy_res),
      .rsp_done_res(rsp_done_res),
      .rsp_status(rsp_status),
      .rsp_humidity_tenths(rsp_humidity_tenths),
      .rsp_temperature_tenths(rsp_temperature_tenths),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic int min_of(input int a, input int b);
      return (a < b) ? a : b;
   endfunction

   // random gaps, except for a recurring calm stretch
   function automatic bit take_gap();
      return ((cycle_count % 512) >= 160) && ($urandom_range(0, 99) < 22);
   endfunction

   function automatic rsp_type step_sensor(input logic line, input logic start);
      rsp_type r;
      logic was_busy;
      logic want_level;
      logic [15:0] pulse;
      logic [7:0] csum;
      logic [7:0] temp_hi;
      logic [15:0] magnitude;
      was_busy = (sense_phase != SENSE_IDLE);
      case (sense_phase)
         SENSE_IDLE: begin
            if (start) begin
               sense_phase = SENSE_DRIVE;
               sense_count = 16'd1;
               bits_seen = '0;
               frame_bits = '0;
            end
         end
         SENSE_DRIVE: begin
            if (sense_count >= cfg_copy.start_low_ticks || sense_count == COUNT_FULL) begin
               sense_phase = SENSE_RELEASE;
               sense_count = '0;
            end else begin
               sense_count++;
            end
         end
         SENSE_RELEASE: begin
            if (sense_count >= cfg_copy.release_ticks || sense_count == COUNT_FULL) begin
               sense_phase = SENSE_RESP_LOW;
               sense_count = '0;
            end else begin
               sense_count++;
            end
         end
         default: ;
      endcase
      // the line is sampled on the same tick the release ends
      if (sense_phase >= SENSE_RESP_LOW) begin
         want_level = (sense_phase == SENSE_RESP_HIGH || sense_phase == SENSE_BIT_HIGH);
         if (line == want_level) begin
            pulse = sense_count;
            sense_count = '0;
            if (sense_phase == SENSE_BIT_MEASURE) begin
               frame_bits = {frame_bits[38:0], pulse > cfg_copy.one_threshold};
               bits_seen++;
               if (bits_seen >= FRAME_BITS) begin
                  csum = frame_bits[39:32] + frame_bits[31:24] + frame_bits[23:16]
                         + frame_bits[15:8];
                  if (csum != frame_bits[7:0]) begin
                     held_status = STATUS_CHECKSUM;
                  end else begin
                     held_humidity = frame_bits[39:24];
                     temp_hi = frame_bits[23:16];
                     magnitude = {temp_hi & MAGNITUDE_MASK, frame_bits[15:8]};
                     // sign-magnitude to two's complement, minus zero gives zero
                     if ((temp_hi & SIGN_MASK) != 0) held_temperature = 16'd0 - magnitude;
                     else held_temperature = magnitude;
                     held_status = STATUS_OK;
                  end
                  sense_phase = SENSE_IDLE;
               end else begin
                  sense_phase = SENSE_BIT_HIGH;
               end
            end else begin
               sense_phase = sense_phase_type'(sense_phase + 4'd1);
            end
         end else if (sense_count >= cfg_copy.timeout_limit || sense_count == COUNT_FULL) begin
            held_status = STATUS_TIMEOUT;
            sense_phase = SENSE_IDLE;
            sense_count = '0;
         end else begin
            sense_count++;
         end
      end
      r.drive_low = (sense_phase == SENSE_DRIVE);
      r.busy_res = (sense_phase != SENSE_IDLE);
      r.done_res = was_busy && (sense_phase == SENSE_IDLE);
      r.status = held_status;
      r.humidity_tenths = held_humidity;
      r.temperature_tenths = held_temperature;
      return r;
   endfunction

   function automatic void push_tick(input logic line, input logic start);
      tick_type t;
      t.line_level = line;
      t.start_request = start;
      tick_backlog.push_back(t);
   endfunction

   // a run of one level; extra ticks count as wrong samples of the next wait
   function automatic int queue_run(input logic level, input int lim);
      int n;
      n = 1 + $urandom_range(0, min_of(lim, 2));
      repeat (n) push_tick(level, $urandom_range(0, 3) == 0);
      return n;
   endfunction

   function automatic int drive_span();
      return ((cfg_copy.start_low_ticks == 0) ? 1 : int'(cfg_copy.start_low_ticks))
             + int'(cfg_copy.release_ticks);
   endfunction

   // start request, sensor response and bit_total data bits of a frame
   function automatic int queue_reading(input int bit_total);
      logic [7:0] hum_hi, hum_lo, temp_hi, temp_lo, check;
      logic [39:0] frame;
      int lim, thr, zmax, dur, k, count, pre;
      bit can_one;
      lim = int'(cfg_copy.timeout_limit);
      thr = int'(cfg_copy.one_threshold);
      zmax = min_of(thr, lim);
      can_one = (thr < lim) && (thr < 64);
      pre = drive_span();
      hum_hi = 8'($urandom);
      hum_lo = 8'($urandom);
      temp_hi = 8'($urandom);
      temp_lo = 8'($urandom);
      if ($urandom_range(0, 5) == 0) begin
         temp_hi = SIGN_MASK;
         temp_lo = 8'h00;
      end
      check = hum_hi + hum_lo + temp_hi + temp_lo;
      if ($urandom_range(0, 4) == 0) check = check ^ 8'($urandom_range(1, 255));
      frame = can_one ? {hum_hi, hum_lo, temp_hi, temp_lo, check} : '0;
      push_tick(1'($urandom), 1'b1);
      for (k = 0; k < pre; k++) push_tick(1'($urandom), $urandom_range(0, 3) == 0);
      count = 1 + pre;
      count += queue_run(1'b0, lim);
      count += queue_run(1'b1, lim);
      count += queue_run(1'b0, lim);
      for (k = 0; k < bit_total; k++) begin
         if (frame[39-k]) dur = thr + 1 + $urandom_range(0, min_of(lim - thr - 1, 3));
         else if (zmax <= 64) dur = $urandom_range((zmax > 3) ? zmax - 3 : 0, zmax);
         else dur = $urandom_range(0, 3);
         repeat (dur + 1) push_tick(1'b1, $urandom_range(0, 3) == 0);
         count += dur + 1;
         if (k == FRAME_BITS - 1) begin
            // start on the closing tick must be ignored
            push_tick(1'b0, 1'($urandom_range(0, 1)));
            count++;
            repeat ($urandom_range(0, 2)) push_tick(1'b0, 1'b0);
         end else begin
            count += queue_run(1'b0, lim);
         end
      end
      return count;
   endfunction

   // a held-high line ends any reading by a timeout
   function automatic void queue_recovery();
      repeat (drive_span() + int'(cfg_copy.timeout_limit) + 4) push_tick(1'b1, 1'b0);
   endfunction

   task automatic settle();
      do begin
         do @(negedge clock);
         while (tick_backlog.size() != 0 || req_valid || expected_readouts.size() != 0);
         if (sense_phase != SENSE_IDLE) repeat (64) push_tick(1'b1, 1'b0);
      end while (sense_phase != SENSE_IDLE);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CFG_WIDTH-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      case (idx)
         CSR_START_LOW_TICKS: cfg_copy.start_low_ticks = value;
         CSR_RELEASE_TICKS:   cfg_copy.release_ticks = value;
         CSR_TIMEOUT_LIMIT:   cfg_copy.timeout_limit = value;
         CSR_ONE_THRESHOLD:   cfg_copy.one_threshold = value;
         default: ;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic apply_config(input logic [15:0] start_low, input logic [15:0] release_len,
                               input logic [15:0] limit, input logic [15:0] threshold);
      write_reg(CSR_START_LOW_TICKS, start_low);
      write_reg(CSR_RELEASE_TICKS, release_len);
      write_reg(CSR_TIMEOUT_LIMIT, limit);
      write_reg(CSR_ONE_THRESHOLD, threshold);
   endtask

   task automatic run_phase(input int budget);
      int added, pick;
      bit short_waits;
      added = 0;
      short_waits = (drive_span() + int'(cfg_copy.timeout_limit)) < 200;
      do begin
         pick = $urandom_range(0, 99);
         if (added == 0 || pick < 70 || !short_waits) begin
            added += queue_reading(FRAME_BITS);
         end else if (pick < 85) begin
            added += queue_reading($urandom_range(0, FRAME_BITS - 1));
            queue_recovery();
         end else begin
            repeat ($urandom_range(4, 24)) push_tick(1'($urandom), $urandom_range(0, 7) == 0);
            queue_recovery();
         end
      end while (added < budget);
      settle();
   endtask

   // request side: model steps on each transfer
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            expected_readouts.push_back(step_sensor(req_line_level, req_start_request));
         if (!req_valid || req_ready) begin
            if (tick_backlog.size() != 0 && !take_gap()) begin
               next_tick = tick_backlog.pop_front();
               req_valid <= 1'b1;
               req_line_level <= next_tick.line_level;
               req_start_request <= next_tick.start_request;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic report_mismatch(input string field, input logic [15:0] exp_v,
                                  input logic [15:0] got_v);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch %s: expected %0h, got %0h at cycle %0d",
                  field, exp_v, got_v, cycle_count);
   endtask

   // response side
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !take_gap();
         if (rsp_valid && rsp_ready) begin
            if (expected_readouts.size() == 0) begin
               report_mismatch("unexpected transfer", 16'h0, 16'h0);
            end else begin
               want = expected_readouts.pop_front();
               if (rsp_drive_low !== want.drive_low)
                  report_mismatch("drive_low", 16'(want.drive_low), 16'(rsp_drive_low));
               if (rsp_busy_res !== want.busy_res)
                  report_mismatch("busy_res", 16'(want.busy_res), 16'(rsp_busy_res));
               if (rsp_done_res !== want.done_res)
                  report_mismatch("done_res", 16'(want.done_res), 16'(rsp_done_res));
               if (rsp_status !== want.status)
                  report_mismatch("status", 16'(want.status), 16'(rsp_status));
               if (rsp_humidity_tenths !== want.humidity_tenths)
                  report_mismatch("humidity_tenths", want.humidity_tenths,
                                  rsp_humidity_tenths);
               if (rsp_temperature_tenths !== want.temperature_tenths)
                  report_mismatch("temperature_tenths", want.temperature_tenths,
                                  rsp_temperature_tenths);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   initial begin
      int k;
      cfg_copy = '{START_LOW_TICKS_RESET, RELEASE_TICKS_RESET, TIMEOUT_LIMIT_RESET,
                   ONE_THRESHOLD_RESET};
      sense_phase = SENSE_IDLE;
      sense_count = '0;
      bits_seen = '0;
      frame_bits = '0;
      held_humidity = '0;
      held_temperature = '0;
      held_status = STATUS_OK;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // zero drive, release and timeout: corner timing of every wait
      apply_config(16'd0, 16'd0, 16'd0, 16'd0);
      for (k = 20; k >= 0; k--) push_tick(DIRECTED_LINE[k], DIRECTED_START[k]);
      settle();
      run_phase(120);

      // pulses just above the threshold and at or below it
      apply_config(16'd3, 16'd2, 16'd4, 16'd3);
      run_phase(1);

      repeat (8) @(negedge clock);
      if (mismatch_count == 0 && expected_readouts.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/dht_pkg.sv
hdl/dht_csr.sv
hdl/dht_decode.sv
hdl/dht_sequencer.sv
hdl/dht22_single_wire_reader.sv
sim/tb.sv
